FILE: rtl/rv32fd_pkg.sv
package rv32fd_pkg;

  // Major opcodes, instruction bits 6:0.
  localparam logic [6:0] OPC_LUI    = 7'b011_0111;
  localparam logic [6:0] OPC_AUIPC  = 7'b001_0111;
  localparam logic [6:0] OPC_JAL    = 7'b110_1111;
  localparam logic [6:0] OPC_JALR   = 7'b110_0111;
  localparam logic [6:0] OPC_LOAD   = 7'b000_0011;
  localparam logic [6:0] OPC_OP_IMM = 7'b001_0011;
  localparam logic [6:0] OPC_BRANCH = 7'b110_0011;
  localparam logic [6:0] OPC_STORE  = 7'b010_0011;
  localparam logic [6:0] OPC_OP     = 7'b011_0011;

  localparam logic [31:0] HALT_WORD  = 32'h0ff0_0513;
  localparam logic [31:0] UPPER_MASK = 32'hFFFF_F000;

  localparam logic [6:0] F7_BASE = 7'b000_0000;
  localparam logic [6:0] F7_ALT  = 7'b010_0000;

  // Micro-op kinds, numbered 4 through 37; zero marks an invalid encoding.
  localparam logic [5:0] K_INVALID = 6'd0;
  localparam logic [5:0] K_JALR    = 6'd4;
  localparam logic [5:0] K_BEQ     = 6'd5;
  localparam logic [5:0] K_BNE     = 6'd6;
  localparam logic [5:0] K_BLT     = 6'd7;
  localparam logic [5:0] K_BGE     = 6'd8;
  localparam logic [5:0] K_BLTU    = 6'd9;
  localparam logic [5:0] K_BGEU    = 6'd10;
  localparam logic [5:0] K_LB      = 6'd11;
  localparam logic [5:0] K_LH      = 6'd12;
  localparam logic [5:0] K_LW      = 6'd13;
  localparam logic [5:0] K_LBU     = 6'd14;
  localparam logic [5:0] K_LHU     = 6'd15;
  localparam logic [5:0] K_SB      = 6'd16;
  localparam logic [5:0] K_SH      = 6'd17;
  localparam logic [5:0] K_SW      = 6'd18;
  localparam logic [5:0] K_ADDI    = 6'd19;
  localparam logic [5:0] K_SLTI    = 6'd20;
  localparam logic [5:0] K_SLTIU   = 6'd21;
  localparam logic [5:0] K_XORI    = 6'd22;
  localparam logic [5:0] K_ORI     = 6'd23;
  localparam logic [5:0] K_ANDI    = 6'd24;
  localparam logic [5:0] K_SLLI    = 6'd25;
  localparam logic [5:0] K_SRLI    = 6'd26;
  localparam logic [5:0] K_SRAI    = 6'd27;
  localparam logic [5:0] K_ADD     = 6'd28;
  localparam logic [5:0] K_SUB     = 6'd29;
  localparam logic [5:0] K_SLL     = 6'd30;
  localparam logic [5:0] K_SLT     = 6'd31;
  localparam logic [5:0] K_SLTU    = 6'd32;
  localparam logic [5:0] K_XOR     = 6'd33;
  localparam logic [5:0] K_SRL     = 6'd34;
  localparam logic [5:0] K_SRA     = 6'd35;
  localparam logic [5:0] K_OR      = 6'd36;
  localparam logic [5:0] K_AND     = 6'd37;

  localparam logic [2:0] G_NONE    = 3'd0;
  localparam logic [2:0] G_ARITH_R = 3'd1;
  localparam logic [2:0] G_ARITH_I = 3'd2;
  localparam logic [2:0] G_LOAD    = 3'd3;
  localparam logic [2:0] G_STORE   = 3'd4;
  localparam logic [2:0] G_BRANCH  = 3'd5;
  localparam logic [2:0] G_OTHER   = 3'd6;

  typedef struct packed {
    logic [5:0]  op_kind;
    logic [2:0]  op_group;
    logic        dest_valid;
    logic [4:0]  dest_reg;
    logic [4:0]  src1_reg;
    logic        src2_valid;
    logic [4:0]  src2_reg;
    logic [31:0] immediate;
    logic [31:0] next_fetch;
    logic        predicted_taken;
    logic        stop_fetch;
    logic        is_halt;
  } uop_t;

endpackage

FILE: rtl/rv32i_fetch_decode_top.sv
// RV32I fetch/decode stage.
// Input channel (in_*): one transaction carries the fetch address and the
// instruction word fetched there. Output channel (out_*): one transaction per
// input carries the decoded micro-op and the next fetch address; the op kind
// and op group travel on out_tuser, everything else on out_tdata.
// LUI, AUIPC and JAL come out as ADDI from x0. Branches are predicted taken.
// JALR and the halt word raise stop_fetch and hold the fetch address.
// The item is captured in an input register, decoded by one level of
// combinational logic and captured in the output register, from which its
// result is taken.
// Throughput: one instruction per clock while out_tready is high. Both
// registers advance together whenever the output register is empty or being
// drained, so in_tready stays high while out_tready is high.
// When the receiver stalls, the output register holds its result and the
// input register fills; in_tready drops only once both are occupied.
// Reset (rst_n low at a clock edge) empties both registers; nothing is
// delivered afterwards until new input transactions arrive.
module rv32i_fetch_decode_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // fetch_address[31:0], instruction_word[63:32]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [87:0] out_tdata,  // dest_valid[0], dest_reg[5:1], src1_reg[10:6],
                                  // src2_valid[11], src2_reg[16:12],
                                  // immediate[48:17], next_fetch[80:49],
                                  // predicted_taken[81], stop_fetch[82],
                                  // is_halt[83], zero[87:84]
  output logic [8:0]  out_tuser   // op_kind[5:0], op_group[8:6]
);
  import rv32fd_pkg::*;

  logic        in_valid_r;
  logic [31:0] pc_r;
  logic [31:0] ir_r;
  logic        out_valid_r;
  uop_t        uop_r;
  uop_t        uop_nxt;
  logic        out_free;
  logic        advance;

  assign out_free  = !out_valid_r || out_tready;
  assign advance   = in_valid_r && out_free;
  assign in_tready = !in_valid_r || out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_tready) begin
        in_valid_r <= in_tvalid;
      end
      if (out_free) begin
        out_valid_r <= in_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      pc_r <= in_tdata[31:0];
      ir_r <= in_tdata[63:32];
    end
    if (advance) begin
      uop_r <= uop_nxt;
    end
  end

  logic [6:0]  opc;
  logic [2:0]  f3;
  logic [6:0]  f7;
  logic [4:0]  rd;
  logic [4:0]  rs1;
  logic [4:0]  rs2;
  logic [31:0] imm_i;
  logic [31:0] imm_s;
  logic [31:0] imm_b;
  logic [31:0] imm_j;
  logic [31:0] imm_u;
  logic [31:0] pc_plus4;

  assign opc      = ir_r[6:0];
  assign f3       = ir_r[14:12];
  assign f7       = ir_r[31:25];
  assign rd       = ir_r[11:7];
  assign rs1      = ir_r[19:15];
  assign rs2      = ir_r[24:20];
  assign imm_i    = {{20{ir_r[31]}}, ir_r[31:20]};
  assign imm_s    = {{20{ir_r[31]}}, ir_r[31:25], ir_r[11:7]};
  assign imm_b    = {{19{ir_r[31]}}, ir_r[31], ir_r[7], ir_r[30:25], ir_r[11:8], 1'b0};
  assign imm_j    = {{11{ir_r[31]}}, ir_r[31], ir_r[19:12], ir_r[20], ir_r[30:21], 1'b0};
  assign imm_u    = ir_r & UPPER_MASK;
  assign pc_plus4 = pc_r + 32'd4;

  always_comb begin
    logic [5:0]  kind;
    logic [2:0]  group;
    logic        dv;
    logic [4:0]  s1;
    logic        s2v;
    logic [31:0] imm;
    logic [31:0] next;
    logic        taken;
    logic        stop;
    logic        halt;
    kind  = K_INVALID;
    group = G_NONE;
    dv    = 1'b0;
    s1    = 5'd0;
    s2v   = 1'b0;
    imm   = 32'd0;
    next  = pc_plus4;
    taken = 1'b0;
    stop  = 1'b0;
    halt  = 1'b0;

    case (opc)
      OPC_LUI: begin
        kind = K_ADDI; group = G_ARITH_I; dv = 1'b1; imm = imm_u;
      end
      OPC_AUIPC: begin
        kind = K_ADDI; group = G_ARITH_I; dv = 1'b1; imm = pc_r + imm_u;
      end
      OPC_JAL: begin
        kind = K_ADDI; group = G_ARITH_I; dv = 1'b1; imm = pc_plus4;
        next = pc_r + imm_j;
      end
      OPC_JALR: begin
        if (f3 == 3'd0) begin
          kind = K_JALR; group = G_OTHER; dv = 1'b1; s1 = rs1;
          imm = imm_i; stop = 1'b1; next = pc_r;
        end
      end
      OPC_LOAD: begin
        case (f3)
          3'd0:    kind = K_LB;
          3'd1:    kind = K_LH;
          3'd2:    kind = K_LW;
          3'd4:    kind = K_LBU;
          3'd5:    kind = K_LHU;
          default: kind = K_INVALID;
        endcase
        if (kind != K_INVALID) begin
          group = G_LOAD; dv = 1'b1; s1 = rs1; imm = imm_i;
        end
      end
      OPC_OP_IMM: begin
        case (f3)
          3'd0:    kind = K_ADDI;
          3'd1:    kind = (f7 == F7_BASE) ? K_SLLI : K_INVALID;
          3'd2:    kind = K_SLTI;
          3'd3:    kind = K_SLTIU;
          3'd4:    kind = K_XORI;
          3'd5:    kind = (f7 == F7_BASE) ? K_SRLI :
                          (f7 == F7_ALT)  ? K_SRAI : K_INVALID;
          3'd6:    kind = K_ORI;
          default: kind = K_ANDI;
        endcase
        if (kind != K_INVALID) begin
          group = G_ARITH_I; dv = 1'b1; s1 = rs1;
          // Shifts carry the shift amount, zero-extended.
          imm = (f3 == 3'd1 || f3 == 3'd5) ? {27'd0, rs2} : imm_i;
        end
      end
      OPC_BRANCH: begin
        case (f3)
          3'd0:    kind = K_BEQ;
          3'd1:    kind = K_BNE;
          3'd4:    kind = K_BLT;
          3'd5:    kind = K_BGE;
          3'd6:    kind = K_BLTU;
          3'd7:    kind = K_BGEU;
          default: kind = K_INVALID;
        endcase
        if (kind != K_INVALID) begin
          group = G_BRANCH; s1 = rs1; s2v = 1'b1; taken = 1'b1;
          imm = imm_b; next = pc_r + imm_b;
        end
      end
      OPC_STORE: begin
        case (f3)
          3'd0:    kind = K_SB;
          3'd1:    kind = K_SH;
          3'd2:    kind = K_SW;
          default: kind = K_INVALID;
        endcase
        if (kind != K_INVALID) begin
          group = G_STORE; s1 = rs1; s2v = 1'b1; imm = imm_s;
        end
      end
      OPC_OP: begin
        if (f7 == F7_BASE) begin
          case (f3)
            3'd0:    kind = K_ADD;
            3'd1:    kind = K_SLL;
            3'd2:    kind = K_SLT;
            3'd3:    kind = K_SLTU;
            3'd4:    kind = K_XOR;
            3'd5:    kind = K_SRL;
            3'd6:    kind = K_OR;
            default: kind = K_AND;
          endcase
        end else if (f7 == F7_ALT && f3 == 3'd0) begin
          kind = K_SUB;
        end else if (f7 == F7_ALT && f3 == 3'd5) begin
          kind = K_SRA;
        end
        if (kind != K_INVALID) begin
          group = G_ARITH_R; dv = 1'b1; s1 = rs1; s2v = 1'b1;
        end
      end
      default: begin
        kind = K_INVALID;
      end
    endcase

    // The halt word decodes as an ADDI but also stops fetching in place.
    if (ir_r == HALT_WORD) begin
      stop = 1'b1; halt = 1'b1; next = pc_r;
    end

    uop_nxt.op_kind         = kind;
    uop_nxt.op_group        = group;
    uop_nxt.dest_valid      = dv;
    uop_nxt.dest_reg        = dv ? rd : 5'd0;
    uop_nxt.src1_reg        = s1;
    uop_nxt.src2_valid      = s2v;
    uop_nxt.src2_reg        = s2v ? rs2 : 5'd0;
    uop_nxt.immediate       = imm;
    uop_nxt.next_fetch      = next;
    uop_nxt.predicted_taken = taken;
    uop_nxt.stop_fetch      = stop;
    uop_nxt.is_halt         = halt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = {uop_r.op_group, uop_r.op_kind};
  assign out_tdata  = {4'd0, uop_r.is_halt, uop_r.stop_fetch, uop_r.predicted_taken,
                       uop_r.next_fetch, uop_r.immediate, uop_r.src2_reg,
                       uop_r.src2_valid, uop_r.src1_reg, uop_r.dest_reg,
                       uop_r.dest_valid};

  // A decoded item waiting in the input register reaches the output next cycle.
  a_advance: assert property (@(posedge clk) disable iff (!rst_n)
    advance |=> out_valid_r)
    else $error("decoded item was lost between input and output registers");

  // Branch prediction is set exactly for the branch group.
  a_taken_group: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (uop_r.predicted_taken == (uop_r.op_group == G_BRANCH)))
    else $error("predicted_taken disagrees with op_group");

  // An invalid op carries no group, no registers and no immediate.
  a_invalid_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && uop_r.op_kind == K_INVALID) |->
      (uop_r.op_group == G_NONE && !uop_r.dest_valid && !uop_r.src2_valid &&
       uop_r.src1_reg == 5'd0 && uop_r.immediate == 32'd0 && !uop_r.stop_fetch))
    else $error("invalid op carries decoded fields");

  // The halt word always stops fetching and is an ADDI.
  a_halt_stop: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && uop_r.is_halt) |-> (uop_r.stop_fetch && uop_r.op_kind == K_ADDI))
    else $error("halt word did not stop fetching");

  // Fetch stops only for JALR or the halt word.
  a_stop_source: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && uop_r.stop_fetch) |-> (uop_r.is_halt || uop_r.op_kind == K_JALR))
    else $error("stop_fetch raised by an unexpected op");

endmodule
